// File: sv/edd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// edd_pkg: shared types and constants of the 1-bit error diffusion ditherer
// Register map, field widths, reset values and the result item type.
// ----------------------------------------------------------------------------
package edd_pkg;

  // build-time defaults
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int ERROR_BITS_DEF = 12;

  // field widths
  localparam int GRAY_BITS      = 8;
  localparam int WIDTH_REG_BITS = 11;
  localparam int HEIGHT_BITS    = 13;
  localparam int ROW_BITS       = 12;
  localparam int FILL_BITS      = 3;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 13;

  // arithmetic constants
  localparam int ROW_LIMIT   = 4096;
  localparam int GRAY_MID    = 127;
  localparam int WHITE_LEVEL = 255;
  localparam int ERR_SHIFT   = 4;    // divide by 16

  // register reset values
  localparam int THRESHOLD_RST = 128;
  localparam int WIDTH_RST     = 1024;
  localparam int HEIGHT_RST    = 768;

  // dither_mode codes
  localparam logic MODE_DIFFUSE   = 1'b0;
  localparam logic MODE_THRESHOLD = 1'b1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MODE      = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_WIDTH     = 2'd2,
    REG_HEIGHT    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [GRAY_BITS-1:0] packed_byte;
    logic                 last_of_frame;
  } out_item_t;

endpackage
`default_nettype wire

// File: sv/edd_pix_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// edd_pix_if: grey pixel stream
// Valid/ready channel carrying one 8-bit grey pixel per transfer.
// ----------------------------------------------------------------------------
interface edd_pix_if;
  logic                           valid;
  logic                           ready;
  logic [edd_pkg::GRAY_BITS-1:0]  gray_level;

  modport source (output valid, output gray_level, input ready);
  modport sink   (input valid, input gray_level, output ready);
endinterface
`default_nettype wire

// File: sv/edd_byte_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// edd_byte_if: packed 1-bit pixel stream
// Valid/ready channel carrying eight packed pixels and an end-of-frame flag.
// ----------------------------------------------------------------------------
interface edd_byte_if;
  logic                           valid;
  logic                           ready;
  logic [edd_pkg::GRAY_BITS-1:0]  packed_byte;
  logic                           last_of_frame;

  modport source (output valid, output packed_byte, output last_of_frame, input ready);
  modport sink   (input valid, input packed_byte, input last_of_frame, output ready);
endinterface
`default_nettype wire

// File: sv/edd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// edd_ram: generic simple dual-port RAM
// One write port, one read port, registered read (returns old data on a
// same-address write).
// ----------------------------------------------------------------------------
module edd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: sv/edd_out_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// edd_out_buf: two-entry output queue
// Decouples the dither pipeline from the consumer of packed bytes.
// ----------------------------------------------------------------------------
module edd_out_buf (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  edd_pkg::out_item_t      push_item,
  output      logic [1:0]         count,
  edd_byte_if.source              out_ch
);

  edd_pkg::out_item_t q_r [2];
  logic               wr_ptr_r, wr_ptr_nxt;
  logic               rd_ptr_r, rd_ptr_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic               pop;

  assign pop                  = out_ch.valid && out_ch.ready;
  assign out_ch.valid         = (cnt_r != 2'd0);
  assign out_ch.packed_byte   = q_r[rd_ptr_r].packed_byte;
  assign out_ch.last_of_frame = q_r[rd_ptr_r].last_of_frame;
  assign count                = cnt_r;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_item;
    end
  end

  // the upstream credit check must keep us from overrunning
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != 2'd2) || pop)
    else $error("output queue overrun");

endmodule
`default_nettype wire

// File: sv/error_diffusion_dither_1bit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// error_diffusion_dither_1bit: 8-bit grey to 1-bit Floyd-Steinberg ditherer
// Raster-order grey pixels in, MSB-first packed bytes out.
// ----------------------------------------------------------------------------
// Takes one grey pixel per clock while in_pix.ready is high, and emits one
// packed byte for every eight pixels, with a zero-padded short byte at frame
// end. The accept cycle issues the row-buffer read at the pixel's column;
// the next cycle adds the collected error, decides the bit, splits the
// error and writes the row buffer back. The row buffer is one MAX_WIDTH x
// ERROR_BITS RAM with a single write port; the right-edge pixel produces
// two row writes, so the second one is held in a pending register and goes
// out while the following column-0 pixel (which never writes) is processed
// or the pipeline idles. A write that lands in the same cycle as a read of
// that column is forwarded. The result leaves through a two-entry queue;
// in_pix.ready drops when that queue holds two bytes, or one byte with
// another in flight. A result goes through stage 1 and the queue before it
// reaches out_byte. The row buffer needs no clearing pass: row 0 ignores
// its read data. Writing dither_mode, image_width or image_height restarts
// the frame; threshold_level applies from the next pixel.
// ----------------------------------------------------------------------------
module error_diffusion_dither_1bit #(
  parameter int MAX_WIDTH  = edd_pkg::MAX_WIDTH_DEF,
  parameter int ERROR_BITS = edd_pkg::ERROR_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [edd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [edd_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  edd_pix_if.sink                                  in_pix,
  edd_byte_if.source                               out_byte
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;   // column index
  localparam int EB = ERROR_BITS;
  localparam int XB = ERROR_BITS + 4;                            // working width
  localparam int WB = ($clog2(MAX_WIDTH + 1) > edd_pkg::WIDTH_REG_BITS) ?
                      $clog2(MAX_WIDTH + 1) : edd_pkg::WIDTH_REG_BITS;
  localparam int HB = edd_pkg::HEIGHT_BITS;
  localparam int GB = edd_pkg::GRAY_BITS;
  localparam int FB = edd_pkg::FILL_BITS;

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  function automatic logic signed [XB-1:0] ext_e(input logic signed [EB-1:0] v);
    return {{(XB-EB){v[EB-1]}}, v};
  endfunction

  function automatic logic signed [EB-1:0] sat_err(input logic signed [XB-1:0] v);
    logic signed [XB-1:0] hi;
    logic signed [XB-1:0] lo;
    hi = {{(XB-EB+1){1'b0}}, {(EB-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[EB-1:0];
    end else if (v < lo) begin
      return lo[EB-1:0];
    end
    return v[EB-1:0];
  endfunction

  // divide by 16, truncating toward zero
  function automatic logic signed [XB-1:0] div16(input logic signed [XB-1:0] p);
    logic signed [XB-1:0] b;
    b = p[XB-1] ? p + $signed(XB'((1 << edd_pkg::ERR_SHIFT) - 1)) : p;
    return b >>> edd_pkg::ERR_SHIFT;
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic                             mode_r;
  logic [GB-1:0]                    thr_r;
  logic [edd_pkg::WIDTH_REG_BITS-1:0] img_w_r;
  logic [HB-1:0]                    img_h_r;
  logic                             restart;

  // geometry or mode writes restart the frame
  assign restart = cfg_we &&
                   ((cfg_index == edd_pkg::REG_MODE) ||
                    (cfg_index == edd_pkg::REG_WIDTH) ||
                    (cfg_index == edd_pkg::REG_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= edd_pkg::MODE_DIFFUSE;
      thr_r   <= GB'(edd_pkg::THRESHOLD_RST);
      img_w_r <= edd_pkg::WIDTH_REG_BITS'(edd_pkg::WIDTH_RST);
      img_h_r <= HB'(edd_pkg::HEIGHT_RST);
    end else if (cfg_we) begin
      case (edd_pkg::cfg_reg_t'(cfg_index))
        edd_pkg::REG_MODE:      mode_r  <= cfg_wdata[0];
        edd_pkg::REG_THRESHOLD: thr_r   <= cfg_wdata[GB-1:0];
        edd_pkg::REG_WIDTH:     img_w_r <= cfg_wdata[edd_pkg::WIDTH_REG_BITS-1:0];
        edd_pkg::REG_HEIGHT:    img_h_r <= cfg_wdata[HB-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry: zero acts as one, oversize clamps
  logic [WB-1:0] w_ext, eff_w;
  logic [HB-1:0] eff_h;

  assign w_ext = WB'(img_w_r);
  assign eff_w = (img_w_r == '0)            ? WB'(1) :
                 (w_ext > WB'(MAX_WIDTH))   ? WB'(MAX_WIDTH) : w_ext;
  assign eff_h = (img_h_r == '0)                         ? HB'(1) :
                 (img_h_r > HB'(edd_pkg::ROW_LIMIT))     ? HB'(edd_pkg::ROW_LIMIT) :
                 img_h_r;

  // --------------------------------------------------------------------------
  // stage 0: position tracking, row buffer read
  // --------------------------------------------------------------------------
  logic [AW-1:0]                 col_r, col_nxt;
  logic [edd_pkg::ROW_BITS-1:0]  row_r, row_nxt;
  logic [FB-1:0]                 fill_r, fill_nxt;
  logic                          in_acc, last_col, last_row, last_pix, emit;
  logic [1:0]                    q_cnt;

  // stage 1 registers
  logic                          s1_v_r;
  logic [GB-1:0]                 s1_gray_r;
  logic [AW-1:0]                 s1_x_r;
  logic                          s1_row_gt0_r, s1_last_col_r, s1_last_pix_r, s1_emit_r;
  logic [FB-1:0]                 s1_fill_r;

  // credit: the queue must hold whatever is in flight plus this pixel's byte
  assign in_pix.ready = (q_cnt == 2'd0) || ((q_cnt == 2'd1) && !(s1_v_r && s1_emit_r));
  assign in_acc       = in_pix.valid && in_pix.ready;

  assign last_col = (WB'(col_r) + WB'(1)) >= eff_w;
  assign last_row = (HB'(row_r) + HB'(1)) >= eff_h;
  assign last_pix = last_col && last_row;
  assign emit     = (&fill_r) || last_pix;

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    fill_nxt = fill_r;
    if (restart) begin
      col_nxt  = '0;
      row_nxt  = '0;
      fill_nxt = '0;
    end else if (in_acc) begin
      fill_nxt = emit ? '0 : fill_r + FB'(1);
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_pix ? '0 : row_r + edd_pkg::ROW_BITS'(1);
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      fill_r <= '0;
      s1_v_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      fill_r <= fill_nxt;
      s1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_gray_r     <= in_pix.gray_level;
      s1_x_r        <= col_r;
      s1_row_gt0_r  <= (row_r != '0);
      s1_last_col_r <= last_col;
      s1_last_pix_r <= last_pix;
      s1_emit_r     <= emit;
      s1_fill_r     <= fill_r;
    end
  end

  // --------------------------------------------------------------------------
  // row buffer
  // --------------------------------------------------------------------------
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [EB-1:0]  wr_data;
  logic [EB-1:0]  ram_q;

  edd_ram #(
    .WIDTH (EB),
    .DEPTH (MAX_WIDTH)
  ) u_row_buf (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (ram_q)
  );

  // --------------------------------------------------------------------------
  // stage 1: error arithmetic
  // --------------------------------------------------------------------------
  logic signed [EB-1:0] right_r, right_nxt;     // error for next pixel in row
  logic signed [EB-1:0] blp_r, blp_nxt;         // partial for column x-1, next row
  logic signed [EB-1:0] bp_r, bp_nxt;           // 1/16 term for column x, next row
  logic                 pend_v_r;               // deferred right-edge write
  logic [AW-1:0]        pend_addr_r;
  logic [EB-1:0]        pend_data_r;
  logic                 fwd_v_r;                // write seen in the read cycle
  logic [AW-1:0]        fwd_addr_r;
  logic [EB-1:0]        fwd_data_r;

  logic                 diff_act, fwd_hit, white, bit_val;
  logic signed [EB-1:0] below, val, left_w, blp_pre, right_new, bp_new;
  logic signed [XB-1:0] sum, err, p7, p3, p5, t7, t3, t5, t1;
  logic                 s1_wr_left, s1_wr_last0;

  assign diff_act = s1_v_r && (mode_r == edd_pkg::MODE_DIFFUSE);
  assign fwd_hit  = fwd_v_r && (fwd_addr_r == s1_x_r);

  always_comb begin
    below = s1_row_gt0_r ? (fwd_hit ? $signed(fwd_data_r) : $signed(ram_q)) : '0;
    sum   = $signed({{(XB-GB){1'b0}}, s1_gray_r}) + ext_e(right_r) + ext_e(below);
    val   = sat_err(sum);
    white = val > $signed(EB'(edd_pkg::GRAY_MID));
    err   = ext_e(val) - (white ? $signed(XB'(edd_pkg::WHITE_LEVEL)) : $signed(XB'(0)));
    p7    = (err <<< 3) - err;
    p3    = (err <<< 1) + err;
    p5    = (err <<< 2) + err;
    t7    = div16(p7);
    t3    = div16(p3);
    t5    = div16(p5);
    t1    = div16(err);
    left_w    = sat_err(ext_e(blp_r) + t3);
    blp_pre   = sat_err(ext_e(bp_r) + t5);
    right_new = sat_err(t7);
    bp_new    = sat_err(t1);
    bit_val   = (mode_r == edd_pkg::MODE_THRESHOLD) ? (s1_gray_r > thr_r) : white;
  end

  always_comb begin
    right_nxt = right_r;
    blp_nxt   = blp_r;
    bp_nxt    = bp_r;
    if (restart) begin
      right_nxt = '0;
      blp_nxt   = '0;
      bp_nxt    = '0;
    end else if (diff_act) begin
      right_nxt = s1_last_col_r ? '0 : right_new;
      blp_nxt   = s1_last_col_r ? '0 : blp_pre;
      bp_nxt    = s1_last_col_r ? '0 : bp_new;
    end
  end

  // write port: the left-neighbor write, or the right-edge write of a
  // one-pixel-wide row, or the right-edge write held from last cycle
  assign s1_wr_left  = diff_act && (s1_x_r != '0);
  assign s1_wr_last0 = diff_act && (s1_x_r == '0) && s1_last_col_r;

  always_comb begin
    wr_en   = s1_wr_left || s1_wr_last0 || pend_v_r;
    wr_addr = pend_addr_r;
    wr_data = pend_data_r;
    if (s1_wr_left) begin
      wr_addr = s1_x_r - AW'(1);
      wr_data = left_w;
    end else if (s1_wr_last0) begin
      wr_addr = '0;
      wr_data = blp_pre;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_r  <= '0;
      blp_r    <= '0;
      bp_r     <= '0;
      pend_v_r <= 1'b0;
      fwd_v_r  <= 1'b0;
    end else begin
      right_r  <= right_nxt;
      blp_r    <= blp_nxt;
      bp_r     <= bp_nxt;
      pend_v_r <= s1_wr_left && s1_last_col_r;
      fwd_v_r  <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= s1_x_r;
    pend_data_r <= blp_pre;
    fwd_addr_r  <= wr_addr;
    fwd_data_r  <= wr_data;
  end

  // --------------------------------------------------------------------------
  // bit packing and output queue
  // --------------------------------------------------------------------------
  logic [GB-1:0]       pack_r, pack_nxt, shift_new;
  edd_pkg::out_item_t  push_item;
  logic                push;

  assign shift_new              = {pack_r[GB-2:0], bit_val};
  assign push                   = s1_v_r && s1_emit_r;
  assign push_item.packed_byte  = shift_new << (~s1_fill_r);   // left-justify short byte
  assign push_item.last_of_frame = s1_last_pix_r;

  always_comb begin
    pack_nxt = pack_r;
    if (restart) begin
      pack_nxt = '0;
    end else if (s1_v_r) begin
      pack_nxt = s1_emit_r ? '0 : shift_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pack_r <= '0;
    end else begin
      pack_r <= pack_nxt;
    end
  end

  edd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .count     (q_cnt),
    .out_ch    (out_byte)
  );

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    WB'(col_r) < eff_w)
    else $error("column counter beyond row width");

  a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(pend_v_r && (s1_wr_left || s1_wr_last0)))
    else $error("row buffer write port collision");

  a_frame_end_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && last_pix) |=> (s1_v_r && s1_emit_r && s1_last_pix_r))
    else $error("last pixel of frame did not flush a byte");

endmodule
`default_nettype wire
